[hdl/reorderable_queue_with_jump_ahead_unit_macros.svh]
// Assertion macros used by the queue controller module.
`ifndef REORDERABLE_QUEUE_WITH_JUMP_AHEAD_UNIT_MACROS_SVH
`define REORDERABLE_QUEUE_WITH_JUMP_AHEAD_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define RQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[hdl/rqja_pkg.sv]
// Package with the constants, codes and control types of the reorderable queue.
package rqja_pkg;
  localparam int Capacity = 16;
  localparam int ValueBits = 32;
  localparam int HandleBits = $clog2(Capacity);
  localparam int CountBits = $clog2(Capacity + 1);

  localparam logic [1:0] ActPush = 2'd0;
  localparam logic [1:0] ActPop = 2'd1;
  localparam logic [1:0] ActQuery = 2'd2;
  localparam logic [1:0] ActJump = 2'd3;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StFull = 2'd2;
  localparam logic [1:0] StDead = 2'd3;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;
endpackage

[hdl/reorderable_queue_with_jump_ahead_unit.sv]
// Top level of the reorderable queue with jump-ahead.
// Each item is latched and its handle matched over all order cells in the load step,
// then the execute step applies the shift of the order cells and writes the result
// register. A new item is taken once the previous one has executed; the result waits
// in its output register while the next item is latched.
module reorderable_queue_with_jump_ahead_unit (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [55:0] s_tdata, // action[1:0], value[33:2], handle[37:34], distance[53:38]
  output logic m_tvalid,
  input  logic m_tready,
  output logic [47:0] m_tdata  // popped_value[31:0], new_handle[35:32], place[39:36],
                               // occupancy[44:40], status[46:45]
);
  rqja_pkg::ctrl_cmd_t cmd;
  logic signed [31:0] popped_value;
  logic [3:0] new_handle;
  logic [3:0] place;
  logic [4:0] occupancy;
  logic [1:0] status;

  rqja_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready), .cmd(cmd)
  );

  rqja_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .action(s_tdata[1:0]), .value(s_tdata[33:2]), .handle(s_tdata[37:34]),
    .distance(s_tdata[53:38]),
    .popped_value(popped_value), .new_handle(new_handle), .place(place),
    .occupancy(occupancy), .status(status)
  );

  assign m_tdata = {1'b0, status, occupancy, place, new_handle, popped_value};
endmodule

[hdl/rqja_ctrl.sv]
// Controller state machine: takes an item, runs the two datapath steps, offers the result.
module rqja_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output rqja_pkg::ctrl_cmd_t cmd
);
  `include "reorderable_queue_with_jump_ahead_unit_macros.svh"
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;
  state_t state, state_next;
  logic   out_valid_next;

  always_comb begin
    state_next = state;
    out_valid_next = out_valid;
    cmd = '0;
    in_ready = 1'b0;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid || out_ready) begin
          cmd.exec = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `RQ_ASSERT_NEXT(a_load_exec, clk, rst, cmd.load, state == S_EXEC, "load must lead to execute")
  `RQ_ASSERT_NEXT(a_exec_valid, clk, rst, cmd.exec, out_valid, "execute must present a result")
  `RQ_ASSERT_IMP(a_exec_free, clk, rst, cmd.exec, !out_valid || out_ready, "result overwritten")
endmodule

[hdl/rqja_datapath.sv]
// Datapath: order cells, handle live bits, value store, count and result register.
module rqja_datapath (
  input  logic clk,
  input  logic rst,
  input  rqja_pkg::ctrl_cmd_t cmd,
  input  logic [1:0] action,
  input  logic signed [31:0] value,
  input  logic [3:0] handle,
  input  logic [15:0] distance,
  output logic signed [31:0] popped_value,
  output logic [3:0] new_handle,
  output logic [3:0] place,
  output logic [4:0] occupancy,
  output logic [1:0] status
);
  localparam int N = rqja_pkg::Capacity;
  localparam int HB = rqja_pkg::HandleBits;
  localparam int CB = rqja_pkg::CountBits;
  localparam int VB = rqja_pkg::ValueBits;

  logic [HB-1:0] order [N];
  logic [VB-1:0] vals [N];
  logic [N-1:0]  live;
  logic [CB-1:0] count;
  logic [1:0]    act_r;
  logic [31:0]   val_r;
  logic [3:0]    hnd_r;
  logic [15:0]   dist_r;
  logic [HB-1:0] pos_r;
  logic [HB-1:0] free_h;
  logic          free_ok;
  logic [HB-1:0] pos_c;
  logic          hnd_ok;
  logic [HB-1:0] dest;

  // Stage one handle match across the cells, and the free handle search used by the execute step.
  always_comb begin
    pos_c = '0;
    for (int k = N - 1; k >= 0; k--) begin
      if (k < count && {{(32-HB){1'b0}}, order[k]} == {28'd0, handle}) begin
        pos_c = HB'(k);
      end
    end
    free_ok = 1'b0;
    free_h = '0;
    for (int h = N - 1; h >= 0; h--) begin
      if (!live[h]) begin
        free_ok = 1'b1;
        free_h = HB'(h);
      end
    end
  end

  assign hnd_ok = (32'(hnd_r) < 32'(N)) && live[HB'(hnd_r)];
  assign dest = ({16'd0, dist_r} >= 32'(pos_r)) ? '0 : HB'(32'(pos_r) - 32'(dist_r));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= action;
      val_r <= value;
      hnd_r <= handle;
      dist_r <= distance;
      pos_r <= pos_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
      count <= '0;
      status <= rqja_pkg::StOk;
      popped_value <= '0;
      new_handle <= '0;
      place <= '0;
    end else if (cmd.exec) begin
      popped_value <= '0;
      new_handle <= '0;
      place <= '0;
      status <= rqja_pkg::StOk;
      case (act_r)
        rqja_pkg::ActPush: begin
          if (count >= CB'(N) || !free_ok) begin
            status <= rqja_pkg::StFull;
          end else begin
            live[free_h] <= 1'b1;
            vals[free_h] <= VB'(val_r);
            order[count[HB-1:0]] <= free_h;
            new_handle <= 4'(free_h);
            place <= 4'(count);
            count <= count + 1'b1;
          end
        end
        rqja_pkg::ActPop: begin
          if (count == '0) begin
            status <= rqja_pkg::StEmpty;
          end else begin
            popped_value <= 32'(signed'(vals[order[0]]));
            live[order[0]] <= 1'b0;
            for (int k = 1; k < N; k++) begin
              if (k < count) begin
                order[k-1] <= order[k];
              end
            end
            count <= count - 1'b1;
          end
        end
        rqja_pkg::ActQuery, rqja_pkg::ActJump: begin
          if (!hnd_ok) begin
            status <= rqja_pkg::StDead;
          end else if (act_r == rqja_pkg::ActJump) begin
            for (int k = 1; k < N; k++) begin
              if (HB'(k) > dest && HB'(k) <= pos_r) begin
                order[k] <= order[k-1];
              end
            end
            order[dest] <= HB'(hnd_r);
            place <= 4'(dest);
          end else begin
            place <= 4'(pos_r);
          end
        end
        default: begin
          status <= rqja_pkg::StOk;
        end
      endcase
    end
  end

  assign occupancy = 5'(count);
endmodule
